FILE: hw/rtl/i3va_pkg.sv
// Shared opcodes and types for the three-lane integer vector ALU.
package i3va_pkg;
   typedef enum logic [4:0] {
      OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MULS = 5'd2, OP_DIVS = 5'd3, OP_MUL = 5'd4,
      OP_NEG = 5'd5, OP_ABS = 5'd6, OP_CROSS = 5'd7, OP_MIN = 5'd8, OP_MAX = 5'd9,
      OP_SIGN = 5'd10, OP_CLAMP = 5'd11, OP_DIV = 5'd12, OP_ADDS = 5'd13,
      OP_SUBS = 5'd14, OP_MODF = 5'd15, OP_DIVF = 5'd16
   } op_type;
   localparam int OP_BITS = 5;
endpackage

FILE: hw/rtl/i3va_lane.sv
// One lane: pipelined ALU with an iterative-stage (one bit per stage) divider.
module i3va_lane #(
   parameter int WIDTH = 32
) (
   input  logic                          clock,
   input  logic [i3va_pkg::OP_BITS-1:0]  op,
   input  logic signed [WIDTH-1:0]       a,
   input  logic signed [WIDTH-1:0]       b,
   input  logic signed [WIDTH-1:0]       c,
   input  logic signed [WIDTH-1:0]       s,
   output logic signed [WIDTH-1:0]       res
);
   // stage 0: register operands and simple results
   logic [i3va_pkg::OP_BITS-1:0] op_ff;
   logic signed [WIDTH-1:0] a_ff, m_ff, simple_ff, d_ff;
   logic signed [WIDTH-1:0] simple_in, d_in;
   always_comb begin
      d_in = (op == i3va_pkg::OP_DIVS) ? s : b;
      case (op)
         i3va_pkg::OP_ADD:  simple_in = a + b;
         i3va_pkg::OP_SUB:  simple_in = a - b;
         i3va_pkg::OP_ADDS: simple_in = a + s;
         i3va_pkg::OP_SUBS: simple_in = a - s;
         i3va_pkg::OP_NEG:  simple_in = -a;
         i3va_pkg::OP_ABS:  simple_in = a[WIDTH-1] ? -a : a;
         i3va_pkg::OP_MIN:  simple_in = (a < b) ? a : b;
         i3va_pkg::OP_MAX:  simple_in = (b < a) ? a : b;
         i3va_pkg::OP_SIGN: simple_in = a[WIDTH-1] ? '1 :
                                        WIDTH'(a != '0);
         i3va_pkg::OP_CLAMP: simple_in = (a < b) ? b : ((c < a) ? c : a);
         default:           simple_in = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      op_ff <= op; a_ff <= a; d_ff <= d_in; simple_ff <= simple_in;
      m_ff <= WIDTH'(a * ((op == i3va_pkg::OP_MULS) ? s : b));
   end
   // divider pipeline: magnitudes, one quotient bit per stage
   logic [WIDTH-1:0] ma, md;
   assign ma = a_ff[WIDTH-1] ? WIDTH'(-a_ff) : a_ff;
   assign md = d_ff[WIDTH-1] ? WIDTH'(-d_ff) : d_ff;
   logic [WIDTH-1:0] rem_ff [WIDTH+1];
   logic [WIDTH-1:0] quo_ff [WIDTH+1];
   logic [WIDTH-1:0] dv_ff  [WIDTH+1];
   logic [WIDTH-1:0] ad_ff  [WIDTH+1];
   logic signed [WIDTH-1:0] sm_ff [WIDTH+1];
   logic [i3va_pkg::OP_BITS-1:0] po_ff [WIDTH+1];
   logic [2:0] sg_ff [WIDTH+1];
   always_ff @(posedge clock) begin
      rem_ff[0] <= '0; quo_ff[0] <= ma; dv_ff[0] <= md; ad_ff[0] <= d_ff;
      po_ff[0] <= op_ff;
      sm_ff[0] <= (op_ff == i3va_pkg::OP_MULS || op_ff == i3va_pkg::OP_MUL) ? m_ff
                                                                          : simple_ff;
      sg_ff[0] <= {a_ff[WIDTH-1], d_ff[WIDTH-1], d_ff == '0};
   end
   for (genvar i = 0; i < WIDTH; i++) begin : g_div
      logic [WIDTH:0] t;
      assign t = {rem_ff[i], quo_ff[i][WIDTH-1]} - {1'b0, dv_ff[i]};
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= t[WIDTH] ? {rem_ff[i][WIDTH-2:0], quo_ff[i][WIDTH-1]}
                                 : t[WIDTH-1:0];
         quo_ff[i+1] <= {quo_ff[i][WIDTH-2:0], ~t[WIDTH]};
         dv_ff[i+1] <= dv_ff[i]; ad_ff[i+1] <= ad_ff[i]; po_ff[i+1] <= po_ff[i];
         sm_ff[i+1] <= sm_ff[i]; sg_ff[i+1] <= sg_ff[i];
      end
   end
   // final sign fixup and selection
   logic [WIDTH-1:0] q, r, uq, ur;
   logic adj;
   assign uq = quo_ff[WIDTH];
   assign ur = rem_ff[WIDTH];
   assign q = (sg_ff[WIDTH][2] ^ sg_ff[WIDTH][1]) ? WIDTH'(-uq) : uq;
   assign r = sg_ff[WIDTH][2] ? WIDTH'(-ur) : ur;
   assign adj = (ur != '0) && (sg_ff[WIDTH][2] ^ sg_ff[WIDTH][1]);
   logic signed [WIDTH-1:0] res_in;
   always_comb begin
      case (po_ff[WIDTH]) inside
         i3va_pkg::OP_DIVS, i3va_pkg::OP_DIV: res_in = q;
         i3va_pkg::OP_DIVF: res_in = adj ? q - 1'b1 : q;
         i3va_pkg::OP_MODF: res_in = adj ? r + ad_ff[WIDTH] : r;
         default:           res_in = sm_ff[WIDTH];
      endcase
      if (sg_ff[WIDTH][0] && (po_ff[WIDTH] == i3va_pkg::OP_DIVS ||
          po_ff[WIDTH] == i3va_pkg::OP_DIV || po_ff[WIDTH] == i3va_pkg::OP_DIVF ||
          po_ff[WIDTH] == i3va_pkg::OP_MODF)) res_in = '0;
   end
   always_ff @(posedge clock) res <= res_in;
endmodule

FILE: hw/rtl/i3va_merge.sv
// Merge stage: lane results, or the cross product built from lane products.
module i3va_merge #(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    is_cross,
   input  logic signed [WIDTH-1:0] a [3],
   input  logic signed [WIDTH-1:0] b [3],
   input  logic signed [WIDTH-1:0] lane [3],
   output logic                    done,
   output logic signed [WIDTH-1:0] r [3]
);
   // lane pipeline depth: operand stage, setup, WIDTH divider stages and output
   localparam int LAT = WIDTH + 3;
   logic signed [WIDTH-1:0] p_ff [6];
   logic signed [WIDTH-1:0] x_ff [LAT-1][3];
   logic [LAT-1:0] v_ff, c_ff;
   always_ff @(posedge clock) begin
      p_ff[0] <= WIDTH'(a[1] * b[2]); p_ff[1] <= WIDTH'(a[2] * b[1]);
      p_ff[2] <= WIDTH'(a[2] * b[0]); p_ff[3] <= WIDTH'(a[0] * b[2]);
      p_ff[4] <= WIDTH'(a[0] * b[1]); p_ff[5] <= WIDTH'(a[1] * b[0]);
      for (int k = 0; k < 3; k++) x_ff[0][k] <= p_ff[2*k] - p_ff[2*k+1];
      for (int i = 1; i < LAT-1; i++) x_ff[i] <= x_ff[i-1];
      c_ff <= {c_ff[LAT-2:0], is_cross};
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[LAT-2:0], start};
   end
   assign done = v_ff[LAT-1];
   // cross flag lines up with the x delay line, which is shorter by the p_ff product register
   for (genvar k = 0; k < 3; k++) begin : g_out
      assign r[k] = c_ff[LAT-1] ? x_ff[LAT-2][k] : lane[k];
   end
   a_done: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT done) else $error("lost request");
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##LAT !done) else $error("result without request");
   a_idle: assert property (@(posedge clock) reset |=> !done) else $error("done after reset");
endmodule

FILE: hw/rtl/int3_vector_alu.sv
// Top level of the three-lane integer vector ALU.
// Drive req_* with start high; busy is always low, so a request is taken
// every cycle. Each lane runs its own ALU, and lane-wise division is a
// pipeline that resolves one quotient bit per stage. Results appear on
// rsp_* with rsp_valid high for one cycle, in request order and with the
// same delay whatever the opcode; throughput is one request per cycle.
// The cross product is formed from six products in the merge stage and is
// aligned with the lane results. Unknown opcodes give a zero vector.
// Reset clears the valid pipeline; requests in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
module int3_vector_alu #(
   parameter int WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [4:0]                   req_operation,
   input  logic signed [WIDTH-1:0]      req_a_x, req_a_y, req_a_z,
   input  logic signed [WIDTH-1:0]      req_b_x, req_b_y, req_b_z,
   input  logic signed [WIDTH-1:0]      req_c_x, req_c_y, req_c_z,
   input  logic signed [WIDTH-1:0]      req_scalar,
   output logic                         rsp_valid,
   output logic signed [WIDTH-1:0]      rsp_r_x, rsp_r_y, rsp_r_z
);
   logic signed [WIDTH-1:0] a [3], b [3], c [3], lane [3], r [3];
   assign a = '{req_a_x, req_a_y, req_a_z};
   assign b = '{req_b_x, req_b_y, req_b_z};
   assign c = '{req_c_x, req_c_y, req_c_z};
   assign busy = 1'b0;
   for (genvar k = 0; k < 3; k++) begin : g_lane
      i3va_lane #(.WIDTH(WIDTH)) u_lane (
         .clock(clock), .op(req_operation), .a(a[k]), .b(b[k]), .c(c[k]),
         .s(req_scalar), .res(lane[k]));
   end
   i3va_merge #(.WIDTH(WIDTH)) u_merge (
      .clock(clock), .reset(reset), .start(start),
      .is_cross(req_operation == i3va_pkg::OP_CROSS), .a(a), .b(b), .lane(lane),
      .done(rsp_valid), .r(r));
   assign rsp_r_x = r[0];
   assign rsp_r_y = r[1];
   assign rsp_r_z = r[2];
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for the three-lane integer vector ALU: random and directed requests.
module tb;
   localparam int W = 32;
   localparam int LATENCY = W + 3;
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

   typedef logic signed [W-1:0] lane_type;
   typedef struct {
      lane_type x, y, z;
   } vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [4:0] req_operation = '0;
   lane_type req_a_x = '0, req_a_y = '0, req_a_z = '0;
   lane_type req_b_x = '0, req_b_y = '0, req_b_z = '0;
   lane_type req_c_x = '0, req_c_y = '0, req_c_z = '0;
   lane_type req_scalar = '0;
   logic rsp_valid;
   lane_type rsp_r_x, rsp_r_y, rsp_r_z;

   vec_type expected_vectors[$];
   int errors = 0;

   int3_vector_alu #(.WIDTH(W)) dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      errors++;
      $display("mismatch %s at %0t", msg, $realtime);
   endtask

   // Truncating quotient and remainder, wrapping at the lane width.
   function automatic void divmod_trunc(input lane_type a, input lane_type b,
                                        output lane_type q, output lane_type r);
      logic [W-1:0] ma, mb;
      ma = a[W-1] ? -a : a;
      mb = b[W-1] ? -b : b;
      q = (a[W-1] != b[W-1]) ? -(ma / mb) : (ma / mb);
      r = a[W-1] ? -(ma % mb) : (ma % mb);
   endfunction

   function automatic lane_type alu_lane(input logic [4:0] op, input lane_type a,
                                         input lane_type b, input lane_type c,
                                         input lane_type s);
      lane_type q, r, d;
      d = (op == i3va_pkg::OP_DIVS) ? s : b;
      if (d != 0) divmod_trunc(a, d, q, r);
      else begin
         q = '0;
         r = '0;
      end
      case (op)
         i3va_pkg::OP_ADD: return a + b;
         i3va_pkg::OP_SUB: return a - b;
         i3va_pkg::OP_MULS: return a * s;
         i3va_pkg::OP_DIVS, i3va_pkg::OP_DIV: return q;
         i3va_pkg::OP_MUL: return a * b;
         i3va_pkg::OP_NEG: return -a;
         i3va_pkg::OP_ABS: return a[W-1] ? -a : a;
         i3va_pkg::OP_MIN: return (a < b) ? a : b;
         i3va_pkg::OP_MAX: return (b < a) ? a : b;
         i3va_pkg::OP_SIGN: return a[W-1] ? lane_type'(-1)
                                          : ((a != 0) ? lane_type'(1) : lane_type'(0));
         i3va_pkg::OP_CLAMP: return (a < b) ? b : ((c < a) ? c : a);
         i3va_pkg::OP_ADDS: return a + s;
         i3va_pkg::OP_SUBS: return a - s;
         i3va_pkg::OP_MODF: return (r != 0 && a[W-1] != d[W-1]) ? r + d : r;
         i3va_pkg::OP_DIVF: return (r != 0 && a[W-1] != d[W-1]) ? q - 1 : q;
         default: return '0;
      endcase
   endfunction

   function automatic vec_type alu_result(input logic [4:0] op, input vec_type a,
                                          input vec_type b, input vec_type c,
                                          input lane_type s);
      vec_type v;
      if (op == i3va_pkg::OP_CROSS) begin
         v.x = a.y * b.z - a.z * b.y;
         v.y = a.z * b.x - a.x * b.z;
         v.z = a.x * b.y - a.y * b.x;
      end else begin
         v.x = alu_lane(op, a.x, b.x, c.x, s);
         v.y = alu_lane(op, a.y, b.y, c.y, s);
         v.z = alu_lane(op, a.z, b.z, c.z, s);
      end
      return v;
   endfunction

   // Hold the request until it is taken, then record its expected result.
   task automatic send_request(input logic [4:0] op, input vec_type a, input vec_type b,
                               input vec_type c, input lane_type s);
      start <= 1'b1;
      req_operation <= op;
      {req_a_x, req_a_y, req_a_z} <= {a.x, a.y, a.z};
      {req_b_x, req_b_y, req_b_z} <= {b.x, b.y, b.z};
      {req_c_x, req_c_y, req_c_z} <= {c.x, c.y, c.z};
      req_scalar <= s;
      do @(posedge clock); while (busy);
      expected_vectors.push_back(alu_result(op, a, b, c, s));
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic lane_type rand_lane();
      case ($urandom_range(0, 7))
         0: return VMIN;
         1: return VMAX;
         2: return lane_type'($urandom_range(0, 6)) - 3;
         3: return lane_type'($urandom_range(0, 200)) - 100;
         default: return lane_type'($urandom);
      endcase
   endfunction

   function automatic vec_type rand_vec();
      vec_type v;
      v.x = rand_lane();
      v.y = rand_lane();
      v.z = rand_lane();
      return v;
   endfunction

   function automatic vec_type splat(input lane_type v);
      vec_type r;
      r.x = v;
      r.y = v;
      r.z = v;
      return r;
   endfunction

   task automatic drain();
      start <= 1'b0;
      while (expected_vectors.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      vec_type mixed, divs;
      mixed.x = VMIN;
      mixed.y = VMAX;
      mixed.z = -7;
      divs.x = -1;
      divs.y = 0;
      divs.z = 2;
      for (int op = 0; op <= i3va_pkg::OP_DIVF; op++)
         send_request(op[4:0], mixed, divs, splat(5), lane_type'(-1));
      send_request(i3va_pkg::OP_DIVS, mixed, divs, divs, '0);
      send_request(i3va_pkg::OP_CLAMP, mixed, splat(10), splat(-10), '0);
      send_request(i3va_pkg::OP_MODF, mixed, splat(-3), divs, '0);
      send_request(i3va_pkg::OP_DIVF, splat(7), splat(-2), divs, '0);
      send_request(5'd17, mixed, divs, divs, VMAX);
      send_request(5'd31, splat(VMAX), splat(VMIN), divs, VMIN);
      send_request(i3va_pkg::OP_ABS, splat(VMIN), divs, divs, '0);
      drain();
   endtask

   task automatic test_random();
      logic [4:0] op;
      for (int i = 0; i < 1700; i++) begin
         op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, i3va_pkg::OP_DIVF));
         send_request(op, rand_vec(), rand_vec(), rand_vec(), rand_lane());
         if (i == 800) drain();
         else if ($urandom_range(0, 3) == 0) idle_gap();
      end
      drain();
   endtask

   always @(posedge clock) begin
      vec_type want;
      if (!reset && rsp_valid) begin
         if (expected_vectors.size() == 0) begin
            report("result with no request outstanding");
         end else begin
            want = expected_vectors.pop_front();
            if (rsp_r_x !== want.x)
               report($sformatf("r_x: got %0d expected %0d", rsp_r_x, want.x));
            if (rsp_r_y !== want.y)
               report($sformatf("r_y: got %0d expected %0d", rsp_r_y, want.y));
            if (rsp_r_z !== want.z)
               report($sformatf("r_z: got %0d expected %0d", rsp_r_z, want.z));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("int3_vector_alu test failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_vectors.size() == 0) begin
         $display("int3_vector_alu test passed");
      end else begin
         $display("int3_vector_alu test failed");
      end
      $finish;
   end
endmodule
